### rtl/core/blm_pkg.sv
`default_nettype none

package blm_pkg;

	localparam int NUM_REGS = 8;
	localparam int THR_NUM  = 7;
	localparam int CFG_AW   = 5;

	typedef enum logic [2:0] {
		REG_CRIT_BELOW = 3'd0,
		REG_LOW_MIN    = 3'd1,
		REG_LOW_MAX    = 3'd2,
		REG_MID_MIN    = 3'd3,
		REG_MID_MAX    = 3'd4,
		REG_HIGH_MIN   = 3'd5,
		REG_HIGH_MAX   = 3'd6,
		REG_PERIOD     = 3'd7
	} reg_idx_t;

	localparam logic [15:0] REG_RESET [NUM_REGS] = '{
		16'd3300, 16'd3300, 16'd3600, 16'd3600,
		16'd3900, 16'd3900, 16'd4200, 16'd1000
	};

	typedef enum logic [2:0] {
		LVL_CRITICAL = 3'd0,
		LVL_LOW      = 3'd1,
		LVL_MID      = 3'd2,
		LVL_HIGH     = 3'd3,
		LVL_INVALID  = 3'd4
	} level_t;

	typedef struct packed {
		level_t level;
		logic   red;
		logic   green;
		logic   checked;
		logic   shutdown;
	} res_st_t;

endpackage

`default_nettype wire

### rtl/core/blm_ifs.sv
`default_nettype none

interface blm_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [15:0] sample_mv;

	modport source (output valid, kind, sample_mv, input ready);
	modport sink (input valid, kind, sample_mv, output ready);
endinterface

interface blm_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] filtered_mv;
	logic [2:0]  level;
	logic        red_led_on;
	logic        green_led_on;
	logic        checked;
	logic        shutdown;

	modport source (output valid, filtered_mv, level, red_led_on, green_led_on, checked,
		shutdown, input ready);
	modport sink (input valid, filtered_mv, level, red_led_on, green_led_on, checked,
		shutdown, output ready);
endinterface

`default_nettype wire

### rtl/core/blm_cfg.sv
`default_nettype none

module blm_cfg import blm_pkg::*; #(
	parameter int WINDOW_LEN = 10,
	parameter int TW = 21
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CFG_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	output logic      [TW-1:0]     thr [THR_NUM],
	output logic      [15:0]       period
);

	localparam logic [TW-1:0] WL = TW'(WINDOW_LEN);

	logic [15:0]   cfg_q [NUM_REGS];
	logic [TW-1:0] thr_q [THR_NUM];
	reg_idx_t      widx;
	logic          wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign widx   = reg_idx_t'(paddr[CFG_AW-1:2]);
	assign prdata = {16'd0, cfg_q[paddr[CFG_AW-1:2]]};
	assign period = cfg_q[REG_PERIOD];

	always_comb begin
		for (int i = 0; i < THR_NUM; i++) begin
			thr[i] = thr_q[i];
		end
	end

	// Thresholds are kept pre-multiplied by the window length so that the
	// level test compares directly against the running sum. The inclusive
	// high bound is stored as one step above.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				cfg_q[i] <= REG_RESET[i];
			end
			for (int i = 0; i < THR_NUM - 1; i++) begin
				thr_q[i] <= TW'(REG_RESET[i]) * WL;
			end
			thr_q[REG_HIGH_MAX] <= (TW'(REG_RESET[REG_HIGH_MAX]) + TW'(1)) * WL;
		end else if (wr) begin
			cfg_q[widx] <= pwdata[15:0];
			unique case (widx)
				REG_CRIT_BELOW, REG_LOW_MIN, REG_LOW_MAX, REG_MID_MIN, REG_MID_MAX,
				REG_HIGH_MIN: begin
					thr_q[widx] <= TW'(pwdata[15:0]) * WL;
				end
				REG_HIGH_MAX: begin
					thr_q[REG_HIGH_MAX] <= (TW'(pwdata[15:0]) + TW'(1)) * WL;
				end
				REG_PERIOD: begin
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/core/blm_ring.sv
`default_nettype none

module blm_ring #(
	parameter int WINDOW_LEN = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [15:0] wr_mv,
	output logic      [15:0] old_mv
);

	localparam int IW = $clog2(WINDOW_LEN);

	logic [15:0]           mem [WINDOW_LEN];
	logic [WINDOW_LEN-1:0] vld_q;
	logic [IW-1:0]         idx_q;
	logic [IW-1:0]         idx_nx;
	logic [15:0]           rd_q;
	logic                  rd_vld_q;

	assign idx_nx = (idx_q == IW'(WINDOW_LEN - 1)) ? '0 : idx_q + IW'(1);
	assign old_mv = rd_vld_q ? rd_q : 16'd0;

	// The entry that the next sample replaces is fetched ahead of time.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx_q] <= wr_mv;
			rd_q       <= mem[idx_nx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			idx_q    <= '0;
			rd_vld_q <= 1'b0;
		end else if (wr_en) begin
			vld_q[idx_q] <= 1'b1;
			rd_vld_q     <= vld_q[idx_nx];
			idx_q        <= idx_nx;
		end
	end

endmodule

`default_nettype wire

### rtl/core/blm_core.sv
`default_nettype none

module blm_core import blm_pkg::*; #(
	parameter int CRITICAL_REPEATS = 3,
	parameter int SW = 17,
	parameter int TW = 21
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          go,
	input  wire logic          en_s2,
	input  wire logic          kind,
	input  wire logic [15:0]   sample_mv,
	input  wire logic [15:0]   old_mv,
	input  wire logic [TW-1:0] thr [THR_NUM],
	input  wire logic [15:0]   period,
	output logic               smp_take,
	output logic               v_s2,
	output logic      [SW-1:0] sum_s2,
	output res_st_t            st_s2
);

	localparam int STW = $clog2(CRITICAL_REPEATS + 1);
	localparam logic [STW-1:0] REP = STW'(CRITICAL_REPEATS);

	logic [SW-1:0]  sum_q;
	logic [15:0]    tick_q;
	logic [STW-1:0] streak_q;
	level_t         level_q;
	logic           red_q;
	logic           green_q;
	logic           halt_q;

	logic [SW-1:0]  sum_nx;
	logic [15:0]    tick_nx;
	logic [STW-1:0] streak_nx;
	logic [STW-1:0] streak_inc;
	level_t         level_nx;
	level_t         lvl;
	logic           red_nx;
	logic           green_nx;
	logic           halt_nx;
	logic           tick_take;
	logic           chk;
	logic [16:0]    tick_inc;
	logic [TW-1:0]  sum_x;

	assign smp_take  = go && !halt_q && !kind;
	assign tick_take = go && !halt_q && kind;
	assign tick_inc  = {1'b0, tick_q} + 17'd1;
	assign chk       = tick_take && (tick_inc >= {1'b0, period});
	assign sum_x     = TW'(sum_q);

	always_comb begin
		if (sum_x < thr[REG_CRIT_BELOW]) begin
			lvl = LVL_CRITICAL;
		end else if (sum_x >= thr[REG_LOW_MIN] && sum_x < thr[REG_LOW_MAX]) begin
			lvl = LVL_LOW;
		end else if (sum_x >= thr[REG_MID_MIN] && sum_x < thr[REG_MID_MAX]) begin
			lvl = LVL_MID;
		end else if (sum_x >= thr[REG_HIGH_MIN] && sum_x < thr[REG_HIGH_MAX]) begin
			lvl = LVL_HIGH;
		end else begin
			lvl = LVL_INVALID;
		end
	end

	assign streak_inc = (streak_q < REP) ? streak_q + STW'(1) : streak_q;

	always_comb begin
		sum_nx    = sum_q;
		tick_nx   = tick_q;
		streak_nx = streak_q;
		level_nx  = level_q;
		red_nx    = red_q;
		green_nx  = green_q;
		halt_nx   = halt_q;
		if (smp_take) begin
			sum_nx = sum_q - SW'(old_mv) + SW'(sample_mv);
		end
		if (tick_take) begin
			tick_nx = chk ? 16'd0 : tick_inc[15:0];
		end
		if (chk) begin
			if (lvl == LVL_CRITICAL) begin
				streak_nx = streak_inc;
				if (streak_inc >= REP) begin
					halt_nx = 1'b1;
				end
			end else begin
				streak_nx = '0;
				if (lvl != level_q) begin
					level_nx = lvl;
					case (lvl)
						LVL_LOW: begin
							red_nx   = 1'b1;
							green_nx = 1'b0;
						end
						LVL_MID: begin
							red_nx   = 1'b1;
							green_nx = 1'b1;
						end
						LVL_HIGH: begin
							red_nx   = 1'b0;
							green_nx = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			tick_q   <= '0;
			streak_q <= '0;
			level_q  <= LVL_INVALID;
			red_q    <= 1'b0;
			green_q  <= 1'b0;
			halt_q   <= 1'b0;
			v_s2     <= 1'b0;
		end else begin
			sum_q    <= sum_nx;
			tick_q   <= tick_nx;
			streak_q <= streak_nx;
			level_q  <= level_nx;
			red_q    <= red_nx;
			green_q  <= green_nx;
			halt_q   <= halt_nx;
			if (en_s2) begin
				v_s2 <= go;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			sum_s2         <= sum_nx;
			st_s2.level    <= level_nx;
			st_s2.red      <= red_nx;
			st_s2.green    <= green_nx;
			st_s2.checked  <= chk;
			st_s2.shutdown <= halt_nx;
		end
	end

endmodule

`default_nettype wire

### rtl/core/blm_out.sv
`default_nettype none

module blm_out import blm_pkg::*; #(
	parameter int WINDOW_LEN = 10,
	parameter int SW = 17
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          v_s2,
	input  wire logic [SW-1:0] sum_s2,
	input  wire res_st_t       st_s2,
	output logic               en_out,
	blm_out_if.source          result
);

	// Mean by reciprocal multiplication, exact for every sum below 2**SW.
	localparam int SH = SW + $clog2(WINDOW_LEN);
	localparam int MW = SW + 1;
	localparam int PW = SW + MW;
	localparam longint unsigned MULT = ((64'd1 << SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
	localparam logic [MW-1:0] MULT_V = MW'(MULT);

	logic [PW-1:0] prod;

	assign prod   = PW'(sum_s2) * PW'(MULT_V);
	assign en_out = !result.valid || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.valid <= 1'b0;
		end else if (en_out) begin
			result.valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s2) begin
			result.filtered_mv  <= prod[SH +: 16];
			result.level        <= st_s2.level;
			result.red_led_on   <= st_s2.red;
			result.green_led_on <= st_s2.green;
			result.checked      <= st_s2.checked;
			result.shutdown     <= st_s2.shutdown;
		end
	end

endmodule

`default_nettype wire

### rtl/core/battery_level_monitor.sv
// Path: an accepted input is held in s1, then s2, then the result register.
// Throughput: one item per cycle; a three-stage pipeline with stage-wise
// flow control keeps accepting while bubbles remain ahead of a stalled result.
// Reset: arst_n asynchronously clears pipeline valids, the sum, tick counter,
// critical streak, LEDs and halt flag, sets the level to invalid and loads
// register defaults; per-entry valid bits make the sample ring read as zero.
`default_nettype none

module battery_level_monitor import blm_pkg::*; #(
	parameter int WINDOW_LEN = 10,
	parameter int CRITICAL_REPEATS = 3
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	blm_in_if.sink                 item,
	blm_out_if.source              result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CFG_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready
);

	localparam int SW = $clog2(65535 * WINDOW_LEN + 1);
	localparam int TW = 17 + $clog2(WINDOW_LEN);

	logic          v_s1;
	logic          kind_s1;
	logic [15:0]   smp_s1;
	logic          en_s1;
	logic          en_s2;
	logic          en_out;
	logic          v_s2;
	logic          go;
	logic          smp_take;
	logic [15:0]   old_mv;
	logic [SW-1:0] sum_s2;
	res_st_t       st_s2;
	logic [TW-1:0] thr [THR_NUM];
	logic [15:0]   period;

	assign en_s2      = !v_s2 || en_out;
	assign en_s1      = !v_s1 || en_s2;
	assign go         = v_s1 && en_s2;
	assign item.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && item.valid) begin
			kind_s1 <= item.kind;
			smp_s1  <= item.sample_mv;
		end
	end

	blm_cfg #(
		.WINDOW_LEN(WINDOW_LEN),
		.TW(TW)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.thr(thr),
		.period(period)
	);

	blm_ring #(
		.WINDOW_LEN(WINDOW_LEN)
	) u_ring (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(smp_take),
		.wr_mv(smp_s1),
		.old_mv(old_mv)
	);

	blm_core #(
		.CRITICAL_REPEATS(CRITICAL_REPEATS),
		.SW(SW),
		.TW(TW)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.go(go),
		.en_s2(en_s2),
		.kind(kind_s1),
		.sample_mv(smp_s1),
		.old_mv(old_mv),
		.thr(thr),
		.period(period),
		.smp_take(smp_take),
		.v_s2(v_s2),
		.sum_s2(sum_s2),
		.st_s2(st_s2)
	);

	blm_out #(
		.WINDOW_LEN(WINDOW_LEN),
		.SW(SW)
	) u_out (
		.clk(clk),
		.arst_n(arst_n),
		.v_s2(v_s2),
		.sum_s2(sum_s2),
		.st_s2(st_s2),
		.en_out(en_out),
		.result(result)
	);

endmodule

`default_nettype wire

### rtl/core/blm_checker.sv
`default_nettype none

module blm_checker import blm_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [2:0] level,
	input wire logic       red_led_on,
	input wire logic       green_led_on,
	input wire logic       checked,
	input wire logic       shutdown
);

	logic out_xfer;
	logic shut_seen_q;

	assign out_xfer = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shut_seen_q <= 1'b0;
		end else if (out_xfer && shutdown) begin
			shut_seen_q <= 1'b1;
		end
	end

	// Once halted, every later transfer reports shutdown and no check.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && shut_seen_q |-> shutdown && !checked)
		else $error("shutdown dropped or check reported after halt");

	// A critical result never becomes the applied level.
	a_no_crit_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> level != LVL_CRITICAL)
		else $error("critical level applied");

	a_led_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> (level != LVL_LOW || (red_led_on && !green_led_on))
			&& (level != LVL_MID || (red_led_on && green_led_on))
			&& (level != LVL_HIGH || (!red_led_on && green_led_on)))
		else $error("LEDs do not match the applied level");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped before transfer");

endmodule

bind battery_level_monitor blm_checker u_blm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.level(result.level),
	.red_led_on(result.red_led_on),
	.green_led_on(result.green_led_on),
	.checked(result.checked),
	.shutdown(result.shutdown)
);

`default_nettype wire
